@@ rtl/ffd_pkg.sv @@
// Shared types and constants for the free-fall duration detector.
package ffd_pkg;

    localparam int ACCEL_W = 16;
    localparam int PROD_W  = 2 * ACCEL_W;   // signed product of two axis values
    localparam int SQ_W    = 31;   // one axis squared, up to 2^30
    localparam int MAG_W   = 32;   // sum of three squares, up to 3 * 2^30
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 8;
    localparam int STEP_W  = 8;
    localparam int OFFS_W  = STEP_W + IDX_W;
    localparam int MIN_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FALL_THRESHOLD_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FALL_SAMPLES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP_MS    = 2'd2;

    localparam logic [MAG_W-1:0]  RST_FALL_THRESHOLD_SQ = 32'd589824;  // 9.0 in Q16.16
    localparam logic [MIN_W-1:0]  RST_MIN_FALL_SAMPLES  = 16'd10;
    localparam logic [STEP_W-1:0] RST_SAMPLE_STEP_MS    = 8'd10;

    typedef struct packed {
        logic [MAG_W-1:0]  fall_threshold_sq;
        logic [MIN_W-1:0]  min_fall_samples;
        logic [STEP_W-1:0] sample_step_ms;
    } t_cfg;

    // Payload of the square stage
    typedef struct packed {
        logic [SQ_W-1:0]   sq_x;
        logic [SQ_W-1:0]   sq_y;
        logic [SQ_W-1:0]   sq_z;
        logic [TIME_W-1:0] packet_time;
        logic [OFFS_W-1:0] time_offs;
    } t_sq_data;

endpackage

@@ rtl/ffd_square.sv @@
// Input register stage: per-axis squares and in-packet time offset.
module ffd_square (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [ffd_pkg::ACCEL_W-1:0] i_accel_x,
    input  logic signed [ffd_pkg::ACCEL_W-1:0] i_accel_y,
    input  logic signed [ffd_pkg::ACCEL_W-1:0] i_accel_z,
    input  logic [ffd_pkg::TIME_W-1:0]   i_packet_time,
    input  logic [ffd_pkg::IDX_W-1:0]    i_sample_index,
    input  logic [ffd_pkg::STEP_W-1:0]   i_sample_step_ms,
    input  logic                         i_stall,
    output logic                         o_sq_valid,
    output ffd_pkg::t_sq_data            o_sq_data
);

    logic              r_valid;
    ffd_pkg::t_sq_data r_data;
    ffd_pkg::t_sq_data n_data;
    logic signed [ffd_pkg::PROD_W-1:0] w_px;
    logic signed [ffd_pkg::PROD_W-1:0] w_py;
    logic signed [ffd_pkg::PROD_W-1:0] w_pz;
    logic w_accept;

    assign o_in_ready = !r_valid || !i_stall;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_px = ffd_pkg::PROD_W'(i_accel_x) * ffd_pkg::PROD_W'(i_accel_x);
    assign w_py = ffd_pkg::PROD_W'(i_accel_y) * ffd_pkg::PROD_W'(i_accel_y);
    assign w_pz = ffd_pkg::PROD_W'(i_accel_z) * ffd_pkg::PROD_W'(i_accel_z);

    always_comb begin
        n_data.sq_x        = w_px[ffd_pkg::SQ_W-1:0];
        n_data.sq_y        = w_py[ffd_pkg::SQ_W-1:0];
        n_data.sq_z        = w_pz[ffd_pkg::SQ_W-1:0];
        n_data.packet_time = i_packet_time;
        n_data.time_offs   = ffd_pkg::OFFS_W'(i_sample_step_ms)
                           * ffd_pkg::OFFS_W'(i_sample_index);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= n_data;
        end
    end

    assign o_sq_valid = r_valid;
    assign o_sq_data  = r_data;

endmodule

@@ rtl/ffd_track.sv @@
// Fall tracking stage: threshold compare, run count, start time and result register.
module ffd_track #(
    parameter int COUNT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ffd_pkg::t_cfg              i_cfg,
    input  logic                       i_sq_valid,
    input  ffd_pkg::t_sq_data          i_sq_data,
    output logic                       o_stall,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ffd_pkg::TIME_W-1:0] o_fall_duration
);

    localparam int CMP_W = (COUNT_BITS > ffd_pkg::MIN_W) ? COUNT_BITS : ffd_pkg::MIN_W;

    logic [COUNT_BITS-1:0]      r_count;
    logic [COUNT_BITS-1:0]      n_count;
    logic [ffd_pkg::TIME_W-1:0] r_start;
    logic [ffd_pkg::TIME_W-1:0] n_start;
    logic                       r_out_valid;
    logic [ffd_pkg::TIME_W-1:0] r_duration;

    logic [ffd_pkg::MAG_W-1:0]  w_mag;
    logic [ffd_pkg::TIME_W-1:0] w_now;
    logic [CMP_W-1:0]           w_count_ext;
    logic [CMP_W-1:0]           w_min_ext;
    logic                       w_falling;
    logic                       w_report;
    logic                       w_adv;

    assign o_stall = r_out_valid && !i_out_ready;
    assign w_adv   = i_sq_valid && !o_stall;

    assign w_mag = ffd_pkg::MAG_W'(i_sq_data.sq_x) + ffd_pkg::MAG_W'(i_sq_data.sq_y)
                 + ffd_pkg::MAG_W'(i_sq_data.sq_z);
    assign w_falling = w_mag < i_cfg.fall_threshold_sq;
    assign w_now = i_sq_data.packet_time + ffd_pkg::TIME_W'(i_sq_data.time_offs);

    assign w_count_ext = CMP_W'(r_count);
    assign w_min_ext   = CMP_W'(i_cfg.min_fall_samples);
    assign w_report    = !w_falling && (w_count_ext > w_min_ext);

    always_comb begin
        n_count = r_count;
        n_start = r_start;
        if (w_falling) begin
            if (r_count == '0) begin
                n_start = w_now;
            end
            // saturate at all ones
            if (!(&r_count)) begin
                n_count = r_count + COUNT_BITS'(1);
            end
        end else begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_count <= n_count;
                r_start <= n_start;
            end
            if (!o_stall) begin
                r_out_valid <= w_adv && w_report;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_duration <= w_now - r_start;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fall_duration = r_duration;

endmodule

@@ rtl/freefall_duration_detector_top.sv @@
// Top level of the free-fall duration detector: config registers and the two stages.
//
// Accepts one accelerometer sample per clock and produces at most one fall duration
// per sample. A result passes two register stages after its sample is accepted: the
// first register stage holds the three axis squares and the in-packet time offset,
// the second compares the squared magnitude, updates the run count and start time
// and loads the result register. Throughput is one sample per cycle whenever the
// result side takes its transactions; a waiting result stalls the input only when
// the square stage is also full. Configuration is taken every cycle and should be
// written only while no sample is in flight.
module freefall_duration_detector_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ffd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ffd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [ffd_pkg::ACCEL_W-1:0]    i_accel_x,
    input  logic signed [ffd_pkg::ACCEL_W-1:0]    i_accel_y,
    input  logic signed [ffd_pkg::ACCEL_W-1:0]    i_accel_z,
    input  logic [ffd_pkg::TIME_W-1:0]            i_packet_time,
    input  logic [ffd_pkg::IDX_W-1:0]             i_sample_index,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ffd_pkg::TIME_W-1:0]            o_fall_duration
);

    ffd_pkg::t_cfg     r_cfg;
    ffd_pkg::t_sq_data w_sq_data;
    logic              w_sq_valid;
    logic              w_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fall_threshold_sq <= ffd_pkg::RST_FALL_THRESHOLD_SQ;
            r_cfg.min_fall_samples  <= ffd_pkg::RST_MIN_FALL_SAMPLES;
            r_cfg.sample_step_ms    <= ffd_pkg::RST_SAMPLE_STEP_MS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ffd_pkg::CFG_FALL_THRESHOLD_SQ: begin
                    r_cfg.fall_threshold_sq <= i_cfg_data[ffd_pkg::MAG_W-1:0];
                end
                ffd_pkg::CFG_MIN_FALL_SAMPLES: begin
                    r_cfg.min_fall_samples <= i_cfg_data[ffd_pkg::MIN_W-1:0];
                end
                ffd_pkg::CFG_SAMPLE_STEP_MS: begin
                    r_cfg.sample_step_ms <= i_cfg_data[ffd_pkg::STEP_W-1:0];
                end
                default: begin
                    // unknown index: write dropped
                end
            endcase
        end
    end

    ffd_square u_square (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_packet_time    (i_packet_time),
        .i_sample_index   (i_sample_index),
        .i_sample_step_ms (r_cfg.sample_step_ms),
        .i_stall          (w_stall),
        .o_sq_valid       (w_sq_valid),
        .o_sq_data        (w_sq_data)
    );

    ffd_track #(
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_sq_valid      (w_sq_valid),
        .i_sq_data       (w_sq_data),
        .o_stall         (w_stall),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_fall_duration (o_fall_duration)
    );

endmodule

@@ rtl/ffd_checker.sv @@
// Port-level assertions for the free-fall duration detector, with its bind.
module ffd_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic [ffd_pkg::TIME_W-1:0]            o_fall_duration
);

    // no result may survive reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_fall_duration))
        else $error("result dropped or changed while stalled");

    // with the result register empty, the input side is never blocked
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // a fresh result must come from an accepted input transaction
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without a matching input transaction");

endmodule

bind freefall_duration_detector_top ffd_checker u_ffd_checker (.*);
